// ----- src/terminal_line_editor_top_assert.svh -----
// Assertion macros for the line editor checker.
// Each expects clk and arst_n in scope.
`ifndef TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define TLE_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TLE_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tle_pkg.sv -----
`default_nettype none

package tle_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int POS_W         = 7;
	localparam int DATA_W        = 8;
	localparam int IDX_W         = 6;
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [POS_W-1:0] LINE_CAP    = POS_W'(LINE_CAPACITY);
	localparam logic [POS_W-1:0] LINE_CAP_M1 = POS_W'(LINE_CAPACITY - 1);

	localparam logic [DATA_W-1:0] KEY_ESC    = 8'h1B;
	localparam logic [DATA_W-1:0] KEY_CSI    = 8'h5B;
	localparam logic [DATA_W-1:0] KEY_SS3    = 8'h4F;
	localparam logic [DATA_W-1:0] KEY_SS3_END = 8'h46;
	localparam logic [DATA_W-1:0] KEY_CR     = 8'h0D;
	localparam logic [DATA_W-1:0] KEY_ETX    = 8'h03;
	localparam logic [DATA_W-1:0] KEY_EOT    = 8'h04;
	localparam logic [DATA_W-1:0] KEY_CAN    = 8'h18;
	localparam logic [DATA_W-1:0] KEY_DEL    = 8'h7F;
	localparam logic [DATA_W-1:0] KEY_BS     = 8'h08;
	localparam logic [DATA_W-1:0] CHAR_FIRST = 8'h20;
	localparam logic [DATA_W-1:0] CHAR_LAST  = 8'h7E;
	localparam logic [DATA_W-1:0] CHAR_HASH  = 8'h23;

	localparam logic [DATA_W-1:0] CSI_HOME   = 8'h31;
	localparam logic [DATA_W-1:0] CSI_INS    = 8'h32;
	localparam logic [DATA_W-1:0] CSI_DEL    = 8'h33;
	localparam logic [DATA_W-1:0] CSI_END    = 8'h34;
	localparam logic [DATA_W-1:0] CSI_PGUP   = 8'h35;
	localparam logic [DATA_W-1:0] CSI_PGDN   = 8'h36;
	localparam logic [DATA_W-1:0] CSI_UP     = 8'h41;
	localparam logic [DATA_W-1:0] CSI_DOWN   = 8'h42;
	localparam logic [DATA_W-1:0] CSI_RIGHT  = 8'h43;
	localparam logic [DATA_W-1:0] CSI_LEFT   = 8'h44;

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_INSERT    = 4'd1,
		ACT_ENTER     = 4'd2,
		ACT_BREAK     = 4'd3,
		ACT_BACKSPACE = 4'd4,
		ACT_DELETE    = 4'd5,
		ACT_CLEAR     = 4'd6,
		ACT_END       = 4'd7,
		ACT_HOME      = 4'd8,
		ACT_TOGGLE    = 4'd9,
		ACT_LEFT      = 4'd10,
		ACT_RIGHT     = 4'd11,
		ACT_IGNORED   = 4'd12
	} action_t;

	typedef struct packed {
		logic              rd;
		action_t           action;
		logic [DATA_W-1:0] data;
		logic [IDX_W-1:0]  index;
	} cmd_t;

	typedef struct packed {
		action_t           action;
		logic [POS_W-1:0]  cursor_pos;
		logic [POS_W-1:0]  line_length;
		logic              insert_on;
		logic              line_ready;
		logic [POS_W-1:0]  ready_length;
		logic              line_is_comment;
		logic [DATA_W-1:0] read_char;
	} result_t;

endpackage

`default_nettype wire

// ----- src/tle_ram.sv -----
`default_nettype none

module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/tle_front.sv -----
`default_nettype none

module tle_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic                      mode,
	input  wire logic [tle_pkg::DATA_W-1:0] rx_byte,
	input  wire logic [tle_pkg::IDX_W-1:0]  read_index,
	output tle_pkg::cmd_t                  cmd
);

	typedef enum logic [2:0] {
		ES_IDLE,
		ES_ESC,
		ES_CSI,
		ES_SS3,
		ES_TILDE
	} esc_state_t;

	esc_state_t        esc_q;
	esc_state_t        esc_d;
	tle_pkg::action_t  act;
	logic              to_tilde;

	always_comb begin
		act      = tle_pkg::ACT_NONE;
		to_tilde = 1'b0;
		if (esc_q == ES_IDLE &&
		    rx_byte inside {[tle_pkg::CHAR_FIRST:tle_pkg::CHAR_LAST]}) begin
			act = tle_pkg::ACT_INSERT;
		end else if (rx_byte == tle_pkg::KEY_CR) begin
			act = tle_pkg::ACT_ENTER;
		end else if (rx_byte == tle_pkg::KEY_ETX) begin
			act = tle_pkg::ACT_BREAK;
		end else if (rx_byte == tle_pkg::KEY_EOT) begin
			act = tle_pkg::ACT_IGNORED;
		end else if (rx_byte inside {tle_pkg::KEY_BS, tle_pkg::KEY_DEL}) begin
			act = tle_pkg::ACT_BACKSPACE;
		end else if (rx_byte == tle_pkg::KEY_CAN) begin
			act = tle_pkg::ACT_DELETE;
		end else if (esc_q == ES_ESC && rx_byte == tle_pkg::KEY_ESC) begin
			act = tle_pkg::ACT_CLEAR;
		end else if (esc_q == ES_SS3 && rx_byte == tle_pkg::KEY_SS3_END) begin
			act = tle_pkg::ACT_END;
		end else if (esc_q == ES_CSI) begin
			case (rx_byte)
				tle_pkg::CSI_HOME: begin
					act      = tle_pkg::ACT_HOME;
					to_tilde = 1'b1;
				end
				tle_pkg::CSI_INS: begin
					act      = tle_pkg::ACT_TOGGLE;
					to_tilde = 1'b1;
				end
				tle_pkg::CSI_DEL: begin
					act      = tle_pkg::ACT_DELETE;
					to_tilde = 1'b1;
				end
				tle_pkg::CSI_END: begin
					act      = tle_pkg::ACT_END;
					to_tilde = 1'b1;
				end
				tle_pkg::CSI_PGUP, tle_pkg::CSI_PGDN: begin
					act      = tle_pkg::ACT_IGNORED;
					to_tilde = 1'b1;
				end
				tle_pkg::CSI_UP, tle_pkg::CSI_DOWN: begin
					act = tle_pkg::ACT_IGNORED;
				end
				tle_pkg::CSI_RIGHT: begin
					act = tle_pkg::ACT_RIGHT;
				end
				tle_pkg::CSI_LEFT: begin
					act = tle_pkg::ACT_LEFT;
				end
				default: begin
					act = tle_pkg::ACT_NONE;
				end
			endcase
		end

		if (rx_byte == tle_pkg::KEY_ESC && esc_q == ES_IDLE) begin
			esc_d = ES_ESC;
		end else if (rx_byte == tle_pkg::KEY_CSI && esc_q == ES_ESC) begin
			esc_d = ES_CSI;
		end else if (rx_byte == tle_pkg::KEY_SS3 && esc_q == ES_ESC) begin
			esc_d = ES_SS3;
		end else begin
			esc_d = ES_IDLE;
		end
		if (to_tilde) begin
			esc_d = ES_TILDE;
		end

		cmd.rd     = mode;
		cmd.action = mode ? tle_pkg::ACT_NONE : act;
		cmd.data   = rx_byte;
		cmd.index  = read_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ES_IDLE;
		end else if (accept && !mode) begin
			esc_q <= esc_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/tle_queue.sv -----
`default_nettype none

module tle_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tle_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output logic               valid,
	output tle_pkg::cmd_t      dout
);

	tle_pkg::cmd_t                 mem_q [tle_pkg::QUEUE_DEPTH];
	logic [tle_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tle_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tle_pkg::QCNT_W-1:0]    cnt_q;

	localparam logic [tle_pkg::QPTR_W-1:0] PTR_LAST = tle_pkg::QPTR_W'(tle_pkg::QUEUE_DEPTH - 1);
	localparam logic [tle_pkg::QCNT_W-1:0] CNT_FULL = tle_pkg::QCNT_W'(tle_pkg::QUEUE_DEPTH);

	assign full  = (cnt_q == CNT_FULL);
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tle_back.sv -----
`default_nettype none

module tle_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire tle_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               clearing,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tle_pkg::result_t   out_res
);

	localparam int AW = tle_pkg::ADDR_W;
	localparam int PW = tle_pkg::POS_W;
	localparam int DW = tle_pkg::DATA_W;
	localparam logic [AW-1:0] ADDR_LAST = AW'(tle_pkg::LINE_CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SHIFT,
		ST_WRITE,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [PW-1:0]     cursor_q;
	logic [PW-1:0]     length_q;
	logic              insert_q;
	tle_pkg::result_t  res_q;
	tle_pkg::result_t  out_res_q;
	logic              out_valid_q;
	logic [PW-1:0]     cnt_q;
	logic [AW-1:0]     src_q;
	logic [AW-1:0]     dst_q;
	logic              down_q;
	logic              pend_s1;
	logic [AW-1:0]     wdst_s1;
	logic              fin_en_q;
	logic [AW-1:0]     fin_addr_q;
	logic [DW-1:0]     fin_data_q;
	logic [AW-1:0]     clr_q;
	logic              rd_ok_q;

	logic [PW-1:0]     top;
	logic [PW-1:0]     n_cursor;
	logic [PW-1:0]     n_length;
	logic              n_insert;
	logic [PW-1:0]     n_cnt;
	logic [AW-1:0]     n_src;
	logic [AW-1:0]     n_dst;
	logic              n_down;
	logic              n_fin_en;
	logic [AW-1:0]     n_fin_addr;
	logic [DW-1:0]     n_fin_data;
	logic              n_read;
	logic [AW-1:0]     n_raddr;
	logic              n_ready;
	logic [PW-1:0]     n_rlen;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DW-1:0]     ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DW-1:0]     ram_rdata;

	tle_ram #(
		.WIDTH (DW),
		.DEPTH (tle_pkg::LINE_CAPACITY)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		top        = (length_q > tle_pkg::LINE_CAP_M1) ? tle_pkg::LINE_CAP_M1 : length_q;
		n_cursor   = cursor_q;
		n_length   = length_q;
		n_insert   = insert_q;
		n_cnt      = '0;
		n_src      = '0;
		n_dst      = '0;
		n_down     = 1'b0;
		n_fin_en   = 1'b0;
		n_fin_addr = '0;
		n_fin_data = '0;
		n_read     = 1'b0;
		n_raddr    = '0;
		n_ready    = 1'b0;
		n_rlen     = '0;
		if (cmd.rd) begin
			n_read  = 1'b1;
			n_raddr = AW'(cmd.index);
		end else begin
			case (cmd.action)
				tle_pkg::ACT_INSERT: begin
					if (insert_q && cursor_q < top) begin
						n_cnt  = top - cursor_q;
						n_src  = AW'(top - 1'b1);
						n_dst  = AW'(top);
						n_down = 1'b1;
					end
					if (cursor_q < tle_pkg::LINE_CAP) begin
						n_fin_en   = 1'b1;
						n_fin_addr = AW'(cursor_q);
						n_fin_data = cmd.data;
						n_cursor   = cursor_q + 1'b1;
						if ((insert_q || cursor_q == length_q) &&
						    length_q < tle_pkg::LINE_CAP) begin
							n_length = length_q + 1'b1;
						end
					end
				end
				tle_pkg::ACT_ENTER: begin
					n_read   = 1'b1;
					n_ready  = (length_q != '0);
					n_rlen   = length_q;
					n_cursor = '0;
					n_length = '0;
				end
				tle_pkg::ACT_BREAK, tle_pkg::ACT_CLEAR: begin
					n_cursor = '0;
					n_length = '0;
				end
				tle_pkg::ACT_BACKSPACE: begin
					if (cursor_q != '0 && cursor_q <= length_q) begin
						n_cnt      = length_q - cursor_q;
						n_src      = AW'(cursor_q);
						n_dst      = AW'(cursor_q - 1'b1);
						n_fin_en   = 1'b1;
						n_fin_addr = AW'(length_q - 1'b1);
						n_cursor   = cursor_q - 1'b1;
						n_length   = length_q - 1'b1;
					end
				end
				tle_pkg::ACT_DELETE: begin
					if (length_q != '0 && cursor_q < length_q) begin
						n_cnt      = length_q - cursor_q - 1'b1;
						n_src      = AW'(cursor_q + 1'b1);
						n_dst      = AW'(cursor_q);
						n_fin_en   = 1'b1;
						n_fin_addr = AW'(length_q - 1'b1);
						n_length   = length_q - 1'b1;
					end
				end
				tle_pkg::ACT_END: begin
					n_cursor = length_q;
				end
				tle_pkg::ACT_HOME: begin
					n_cursor = '0;
				end
				tle_pkg::ACT_TOGGLE: begin
					n_insert = ~insert_q;
				end
				tle_pkg::ACT_LEFT: begin
					if (cursor_q != '0) begin
						n_cursor = cursor_q - 1'b1;
					end
				end
				tle_pkg::ACT_RIGHT: begin
					if (cursor_q < length_q) begin
						n_cursor = cursor_q + 1'b1;
					end
				end
				default: begin
					n_cursor = cursor_q;
				end
			endcase
		end
	end

	always_comb begin
		ram_raddr = (state_q == ST_IDLE) ? n_raddr : src_q;
		ram_we    = 1'b0;
		ram_waddr = fin_addr_q;
		ram_wdata = fin_data_q;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wdst_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == ST_WRITE) begin
			ram_we = 1'b1;
		end
	end

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign clearing  = (state_q == ST_CLEAR);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cursor_q    <= '0;
			length_q    <= '0;
			insert_q    <= 1'b1;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			clr_q       <= '0;
			cnt_q       <= '0;
			fin_en_q    <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SHIFT) && (cnt_q != '0);
			wdst_s1 <= dst_q;
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cursor_q   <= n_cursor;
						length_q   <= n_length;
						insert_q   <= n_insert;
						cnt_q      <= n_cnt;
						src_q      <= n_src;
						dst_q      <= n_dst;
						down_q     <= n_down;
						fin_en_q   <= n_fin_en;
						fin_addr_q <= n_fin_addr;
						fin_data_q <= n_fin_data;
						rd_ok_q    <= cmd.rd && (PW'(cmd.index) < tle_pkg::LINE_CAP);
						res_q.action          <= cmd.action;
						res_q.cursor_pos      <= n_cursor;
						res_q.line_length     <= n_length;
						res_q.insert_on       <= n_insert;
						res_q.line_ready      <= n_ready;
						res_q.ready_length    <= n_ready ? n_rlen : '0;
						res_q.line_is_comment <= 1'b0;
						res_q.read_char       <= '0;
						if (n_read) begin
							state_q <= ST_RDWAIT;
						end else if (n_cnt != '0) begin
							state_q <= ST_SHIFT;
						end else if (n_fin_en) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SHIFT: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
						src_q <= down_q ? src_q - 1'b1 : src_q + 1'b1;
						dst_q <= down_q ? dst_q - 1'b1 : dst_q + 1'b1;
					end else if (!pend_s1) begin
						state_q <= fin_en_q ? ST_WRITE : ST_DONE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_RDWAIT: begin
					res_q.read_char       <= rd_ok_q ? ram_rdata : '0;
					res_q.line_is_comment <= res_q.line_ready &&
					                         (ram_rdata == tle_pkg::CHAR_HASH);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_res_q   <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/terminal_line_editor_top.sv -----
// Channel   Handshake              Fields
// in        in_valid / in_stall    mode, rx_byte, read_index
// out       out_valid / out_stall  action, cursor_pos, line_length, insert_on,
//                                  line_ready, ready_length, line_is_comment, read_char
//
// After reset the line RAM is zeroed address by address; in_stall stays high meanwhile.
// A transaction enters a two-entry queue; the executor goes from idle to done for keys
// that leave the RAM alone, via read-wait for enter and reads, via write for single-entry
// writes, and via shift then write when insert, backspace or delete shifts up to 63 chars.
// in_stall rises while the queue is full; a stalled result holds the executor.
`default_nettype none

module terminal_line_editor_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       mode,
	input  wire logic [tle_pkg::DATA_W-1:0] rx_byte,
	input  wire logic [tle_pkg::IDX_W-1:0]  read_index,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [3:0]                      action,
	output logic [tle_pkg::POS_W-1:0]       cursor_pos,
	output logic [tle_pkg::POS_W-1:0]       line_length,
	output logic                            insert_on,
	output logic                            line_ready,
	output logic [tle_pkg::POS_W-1:0]       ready_length,
	output logic                            line_is_comment,
	output logic [tle_pkg::DATA_W-1:0]      read_char
);

	tle_pkg::cmd_t     front_cmd;
	tle_pkg::cmd_t     head_cmd;
	tle_pkg::result_t  res;
	logic              accept;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic              clearing;

	assign in_stall = q_full | clearing;
	assign accept   = in_valid & ~in_stall;

	tle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.cmd        (front_cmd)
	);

	tle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (head_cmd)
	);

	tle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign action          = res.action;
	assign cursor_pos      = res.cursor_pos;
	assign line_length     = res.line_length;
	assign insert_on       = res.insert_on;
	assign line_ready      = res.line_ready;
	assign ready_length    = res.ready_length;
	assign line_is_comment = res.line_is_comment;
	assign read_char       = res.read_char;

endmodule

`default_nettype wire

// ----- src/tle_checker.sv -----
`default_nettype none

`include "terminal_line_editor_top_assert.svh"

module tle_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [3:0]                 action,
	input wire logic [tle_pkg::POS_W-1:0]  cursor_pos,
	input wire logic [tle_pkg::POS_W-1:0]  line_length,
	input wire logic                       line_ready,
	input wire logic [tle_pkg::POS_W-1:0]  ready_length,
	input wire logic                       line_is_comment,
	input wire logic [tle_pkg::DATA_W-1:0] read_char
);

	`TLE_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(action) && $stable(cursor_pos), "stalled result changed")
	`TLE_CHECK_NOW(a_ready_enter, out_valid && line_ready, action == tle_pkg::ACT_ENTER && ready_length != 0 && line_length == 0 && cursor_pos == 0, "line ready without enter")
	`TLE_CHECK_NOW(a_cursor_bound, out_valid, cursor_pos <= line_length && line_length <= tle_pkg::LINE_CAP, "cursor or length out of range")
	`TLE_CHECK_NOW(a_no_ready_fields, out_valid && !line_ready, ready_length == 0 && !line_is_comment, "completed line fields without line ready")
	`TLE_CHECK_NOW(a_read_char_zero, out_valid && action != tle_pkg::ACT_NONE, read_char == 0, "read data on an edit result")

endmodule

bind terminal_line_editor_top tle_checker u_tle_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.action          (action),
	.cursor_pos      (cursor_pos),
	.line_length     (line_length),
	.line_ready      (line_ready),
	.ready_length    (ready_length),
	.line_is_comment (line_is_comment),
	.read_char       (read_char)
);

`default_nettype wire
